// ===== src/lbps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer: shared definitions
// Event codes, register indexes and the beat types passed between the stages.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int TICK_MS = 25;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_SELECT   = 2'd1;
    localparam logic [1:0] KIND_OVERRIDE = 2'd2;
    localparam logic [1:0] KIND_ID_START = 2'd3;

    localparam logic CFG_HW_REV = 1'b0;
    localparam logic CFG_FW_REV = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] pattern;
        logic       override_on;
    } item_t;

    typedef struct packed {
        logic led_on;
        logic led_refresh;
    } result_t;

    typedef enum logic [2:0] {
        ID_LEAD,
        ID_HW_ON,
        ID_HW_OFF,
        ID_GAP,
        ID_FW_ON,
        ID_FW_OFF,
        ID_TAIL,
        ID_DONE
    } id_step_t;

endpackage

// ===== src/lbps_in_reg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer: input register
// Holds one incoming event beat until the player consumes it.
// ----------------------------------------------------------------------------
module lbps_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lbps_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output lbps_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    lbps_pkg::item_t item_reg;
    logic            accept;

    assign in_stall   = valid_reg & ~take;
    assign accept     = in_valid & ~in_stall;
    assign valid_next = accept | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/lbps_player.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer: pattern player
// Holds the sequencer state and works out the LED level for each event beat.
// ----------------------------------------------------------------------------
module lbps_player (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              step,
    input  lbps_pkg::item_t   item,
    output lbps_pkg::result_t result
);

    typedef struct packed {
        logic       nz;
        logic       level;
        logic [6:0] mag;
    } cmd_t;

    localparam int TICK_EFF      = (lbps_pkg::TICK_MS < 1) ? 1 : lbps_pkg::TICK_MS;
    localparam int PATTERN_COUNT = 11;
    localparam int ROW_LEN       = 5;

    function automatic cmd_t make_cmd(int ms);
        int   mag;
        int   t;
        cmd_t c;
        mag = (ms < 0) ? -ms : ms;
        t   = (mag >= TICK_EFF) ? mag / TICK_EFF : 1;
        if (t > 127)
        begin
            t = 127;
        end
        c.nz    = (ms != 0);
        c.level = (ms > 0);
        c.mag   = 7'(t);
        return c;
    endfunction

    localparam cmd_t CMD_ZERO    = '0;
    localparam cmd_t CMD_ID_LEAD = make_cmd(-1000);
    localparam cmd_t CMD_HW_ON   = make_cmd(200);
    localparam cmd_t CMD_HW_OFF  = make_cmd(-800);
    localparam cmd_t CMD_GAP     = make_cmd(-1700);
    localparam cmd_t CMD_FW_ON   = make_cmd(800);
    localparam cmd_t CMD_FW_OFF  = make_cmd(-200);
    localparam cmd_t CMD_TAIL    = make_cmd(-2300);
    localparam cmd_t CMD_OVR_ON  = make_cmd(50);
    localparam cmd_t CMD_OVR_OFF = make_cmd(-50);

    localparam cmd_t PATTERN_ROM [PATTERN_COUNT][ROW_LEN] = '{
        '{CMD_ZERO, CMD_ZERO, CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(-200), CMD_ZERO, CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(200), CMD_ZERO, CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(25), make_cmd(-25), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(50), make_cmd(-50), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(100), make_cmd(-100), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(200), make_cmd(-200), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(500), make_cmd(-500), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(25), make_cmd(-2975), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(950), make_cmd(-50), CMD_ZERO, CMD_ZERO, CMD_ZERO},
        '{make_cmd(850), make_cmd(-50), make_cmd(50), make_cmd(-50), CMD_ZERO}
    };

    localparam logic [7:0] HW_REV_TWO   = 8'd70;
    localparam logic [7:0] HW_REV_THREE = 8'd71;

    logic [7:0]         hw_rev_reg;
    logic [7:0]         fw_rev_reg;
    logic [3:0]         pattern_reg;
    logic [3:0]         pattern_next;
    logic [2:0]         index_reg;
    logic [2:0]         index_next;
    logic [6:0]         hold_reg;
    logic [6:0]         hold_next;
    logic               led_reg;
    logic               led_next;
    logic               id_active_reg;
    logic               id_active_next;
    lbps_pkg::id_step_t id_step_reg;
    lbps_pkg::id_step_t id_step_next;
    lbps_pkg::id_step_t id_step_adv;
    logic [7:0]         hw_left_reg;
    logic [7:0]         hw_left_next;
    logic [7:0]         fw_left_reg;
    logic [7:0]         fw_left_next;
    logic               ovr_en_reg;
    logic               ovr_en_next;
    logic [1:0]         ovr_index_reg;
    logic [1:0]         ovr_index_next;
    logic [7:0]         hw_dec;
    logic [7:0]         fw_dec;
    cmd_t               main_cmd;
    cmd_t               id_cmd;
    cmd_t               ovr_cmd;
    cmd_t               fetched;
    logic               refresh;

    assign hw_dec = hw_left_reg - 8'd1;
    assign fw_dec = fw_left_reg - 8'd1;

    always_comb
    begin
        if ((pattern_reg < 4'(PATTERN_COUNT)) && (index_reg < 3'(ROW_LEN)))
        begin
            main_cmd = PATTERN_ROM[pattern_reg][index_reg];
        end
        else
        begin
            main_cmd = CMD_ZERO;
        end
    end

    always_comb
    begin
        case (ovr_index_reg)
            2'd0:    ovr_cmd = CMD_OVR_ON;
            2'd1:    ovr_cmd = CMD_OVR_OFF;
            default: ovr_cmd = CMD_ZERO;
        endcase
    end

    // Output decode of the show-ID sequence.
    always_comb
    begin
        case (id_step_reg)
            lbps_pkg::ID_LEAD:   id_cmd = CMD_ID_LEAD;
            lbps_pkg::ID_HW_ON:  id_cmd = CMD_HW_ON;
            lbps_pkg::ID_HW_OFF: id_cmd = CMD_HW_OFF;
            lbps_pkg::ID_GAP:    id_cmd = CMD_GAP;
            lbps_pkg::ID_FW_ON:  id_cmd = CMD_FW_ON;
            lbps_pkg::ID_FW_OFF: id_cmd = CMD_FW_OFF;
            lbps_pkg::ID_TAIL:   id_cmd = CMD_TAIL;
            default:             id_cmd = CMD_ZERO;
        endcase
    end

    // Next step of the show-ID sequence.
    always_comb
    begin
        case (id_step_reg)
            lbps_pkg::ID_LEAD:   id_step_adv = lbps_pkg::ID_HW_ON;
            lbps_pkg::ID_HW_ON:  id_step_adv = lbps_pkg::ID_HW_OFF;
            lbps_pkg::ID_HW_OFF:
                id_step_adv = (hw_dec != 8'd0) ? lbps_pkg::ID_HW_ON : lbps_pkg::ID_GAP;
            lbps_pkg::ID_GAP:    id_step_adv = lbps_pkg::ID_FW_ON;
            lbps_pkg::ID_FW_ON:  id_step_adv = lbps_pkg::ID_FW_OFF;
            lbps_pkg::ID_FW_OFF:
                id_step_adv = (fw_dec != 8'd0) ? lbps_pkg::ID_FW_ON : lbps_pkg::ID_TAIL;
            lbps_pkg::ID_TAIL:   id_step_adv = lbps_pkg::ID_DONE;
            default:             id_step_adv = lbps_pkg::ID_LEAD;
        endcase
    end

    always_comb
    begin
        pattern_next   = pattern_reg;
        index_next     = index_reg;
        hold_next      = hold_reg;
        led_next       = led_reg;
        id_active_next = id_active_reg;
        id_step_next   = id_step_reg;
        hw_left_next   = hw_left_reg;
        fw_left_next   = fw_left_reg;
        ovr_en_next    = ovr_en_reg;
        ovr_index_next = ovr_index_reg;
        fetched        = CMD_ZERO;
        refresh        = 1'b0;
        if (step)
        begin
            case (item.kind)
                lbps_pkg::KIND_TICK:
                begin
                    if (hold_reg != 7'd0)
                    begin
                        hold_next = hold_reg - 7'd1;
                    end
                    else
                    begin
                        // The main pointer moves on even when its command is replaced.
                        index_next = main_cmd.nz ? (index_reg + 3'd1) : 3'd0;
                        if (id_active_reg)
                        begin
                            fetched      = id_cmd;
                            id_step_next = id_step_adv;
                            if (id_step_reg == lbps_pkg::ID_HW_OFF)
                            begin
                                hw_left_next = hw_dec;
                            end
                            if (id_step_reg == lbps_pkg::ID_FW_OFF)
                            begin
                                fw_left_next = fw_dec;
                            end
                            if (id_step_reg == lbps_pkg::ID_DONE)
                            begin
                                id_active_next = 1'b0;
                            end
                        end
                        else if (ovr_en_reg)
                        begin
                            fetched        = ovr_cmd;
                            ovr_index_next = ovr_cmd.nz ? (ovr_index_reg + 2'd1) : 2'd0;
                        end
                        else
                        begin
                            fetched = main_cmd;
                        end
                        if (fetched.nz)
                        begin
                            led_next  = fetched.level;
                            hold_next = fetched.mag - 7'd1;
                            refresh   = 1'b1;
                        end
                    end
                end
                lbps_pkg::KIND_SELECT:
                begin
                    if (item.pattern < 4'(PATTERN_COUNT))
                    begin
                        pattern_next = item.pattern;
                        index_next   = 3'd0;
                        hold_next    = 7'd0;
                    end
                end
                lbps_pkg::KIND_OVERRIDE:
                begin
                    ovr_en_next = item.override_on;
                end
                lbps_pkg::KIND_ID_START:
                begin
                    id_active_next = 1'b1;
                    if (hw_rev_reg == HW_REV_TWO)
                    begin
                        hw_left_next = 8'd2;
                    end
                    else if (hw_rev_reg == HW_REV_THREE)
                    begin
                        hw_left_next = 8'd3;
                    end
                    else
                    begin
                        hw_left_next = 8'd1;
                    end
                    fw_left_next = fw_rev_reg + 8'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.led_on      = led_next;
    assign result.led_refresh = refresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_rev_reg <= 8'd0;
            fw_rev_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lbps_pkg::CFG_HW_REV: hw_rev_reg <= cfg_data;
                lbps_pkg::CFG_FW_REV: fw_rev_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= 4'd0;
            index_reg     <= 3'd0;
            hold_reg      <= 7'd0;
            led_reg       <= 1'b0;
            id_active_reg <= 1'b0;
            id_step_reg   <= lbps_pkg::ID_LEAD;
            hw_left_reg   <= 8'd0;
            fw_left_reg   <= 8'd0;
            ovr_en_reg    <= 1'b0;
            ovr_index_reg <= 2'd0;
        end
        else
        begin
            pattern_reg   <= pattern_next;
            index_reg     <= index_next;
            hold_reg      <= hold_next;
            led_reg       <= led_next;
            id_active_reg <= id_active_next;
            id_step_reg   <= id_step_next;
            hw_left_reg   <= hw_left_next;
            fw_left_reg   <= fw_left_next;
            ovr_en_reg    <= ovr_en_next;
            ovr_index_reg <= ovr_index_next;
        end
    end

    a_hold_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.kind == lbps_pkg::KIND_TICK) && (hold_reg != 7'd0))
        |=> (hold_reg == 7'($past(hold_reg) - 7'd1)))
        else $error("Hold counter did not count down on a tick.");

    a_id_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.kind == lbps_pkg::KIND_ID_START)) |=> id_active_reg)
        else $error("Show-ID start did not activate the sequence.");

    a_id_idle_at_lead: assert property (@(posedge clk) disable iff (!rst_n)
        !id_active_reg |-> (id_step_reg == lbps_pkg::ID_LEAD))
        else $error("Show-ID step left its first step while inactive.");

    a_ovr_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovr_index_reg != 2'd3)
        else $error("Override index reached an unused entry.");

endmodule

// ===== src/lbps_out_reg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer: result register
// Holds one result beat and lets the next event through while it is empty or being taken.
// ----------------------------------------------------------------------------
module lbps_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              take,
    input  lbps_pkg::result_t result,
    output logic              out_valid,
    input  logic              out_stall,
    output lbps_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    lbps_pkg::result_t result_reg;

    assign take       = item_valid & (~valid_reg | ~out_stall);
    assign valid_next = take | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== src/led_blink_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern sequencer
// Tick-driven LED pattern player with show-ID and override sequences.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | kind, pattern, override_on
//  out     | output    | out_valid/out_stall | led_on, led_refresh
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Every event beat gives exactly one result beat through the input register and
// then the result register. One beat is accepted per cycle unless a stalled
// result backs up; they set the rate, the whole state update done between them.
// Reset clears all state at once; no clearing pass is needed.
// A stalled result holds; one further event waits in the input register.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [3:0] pattern,
    input  logic       override_on,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       led_on,
    output logic       led_refresh,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    lbps_pkg::item_t   in_item;
    lbps_pkg::item_t   item;
    lbps_pkg::result_t result;
    lbps_pkg::result_t out_result;
    logic              item_valid;
    logic              take;

    assign in_item.kind        = kind;
    assign in_item.pattern     = pattern;
    assign in_item.override_on = override_on;

    lbps_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    lbps_player u_player (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (take),
        .item      (item),
        .result    (result)
    );

    lbps_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .take       (take),
        .result     (result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign led_on      = out_result.led_on;
    assign led_refresh = out_result.led_refresh;

    a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("A consumed event did not produce a result beat.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid && out_valid && out_stall))
        else $error("Input stalled while the pipeline could move.");

    a_held_event_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !out_valid) |-> take)
        else $error("A waiting event was not consumed by an empty result register.");

endmodule
